### rtl/assert_macros.svh
// assertion macros for the rtl files, included by twdp_acc
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define TW_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define TW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TW_ASSERT_ALWAYS(lbl, cond)
`define TW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/twdp_pkg.sv
// shared types and constants of the ternary weight dot product block
`default_nettype none

package twdp_pkg;

  localparam int LANES  = 8;
  localparam int ACT_W  = 8;
  localparam int CODE_W = 2;
  localparam int CNT_W  = 4;
  localparam int TERM_W = ACT_W + 1;
  localparam int PSUM_W = TERM_W + $clog2(LANES);
  localparam int ACC_W  = 32;

  localparam logic [CODE_W-1:0] CODE_PLUS  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS = 2'd2;

  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [PSUM_W-1:0] psum_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    psum_t psum;
  } beat_t;

endpackage

`default_nettype wire

### rtl/twdp_lane.sv
// one lane: turns an activation and its weight code into a signed term
`default_nettype none

module twdp_lane (
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  act,
  input  wire logic        [twdp_pkg::CODE_W-1:0] code,
  input  wire logic                               enable,
  output twdp_pkg::term_t                         term
);

  twdp_pkg::term_t act_ext;

  assign act_ext = twdp_pkg::TERM_W'(act);

  always_comb begin
    term = '0;
    if (enable) begin
      case (code)
        twdp_pkg::CODE_PLUS:  term = act_ext;
        twdp_pkg::CODE_MINUS: term = -act_ext;
        default:              term = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/twdp_sum.sv
// merges the lane terms of one beat and holds the partial sum in a stage register
`default_nettype none

module twdp_sum (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire twdp_pkg::term_t terms [twdp_pkg::LANES],
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_stall,
  input  wire logic            adv,
  output twdp_pkg::beat_t      beat
);

  logic              valid_r;
  logic              valid_nxt;
  logic              last_r;
  twdp_pkg::psum_t   psum_r;
  twdp_pkg::psum_t   psum_nxt;
  twdp_pkg::psum_t   pair_sum [twdp_pkg::LANES/2];
  twdp_pkg::psum_t   quad_sum [twdp_pkg::LANES/4];
  logic              accept;

  // three-level adder tree over the eight lanes
  always_comb begin
    for (int i = 0; i < twdp_pkg::LANES/2; i++) begin
      pair_sum[i] = twdp_pkg::PSUM_W'(terms[2*i]) + twdp_pkg::PSUM_W'(terms[2*i+1]);
    end
    for (int i = 0; i < twdp_pkg::LANES/4; i++) begin
      quad_sum[i] = pair_sum[2*i] + pair_sum[2*i+1];
    end
    psum_nxt = quad_sum[0] + quad_sum[1];
  end

  assign in_stall  = valid_r & ~adv;
  assign accept    = in_valid & ~in_stall;
  assign valid_nxt = accept | (valid_r & ~adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last;
      psum_r <= psum_nxt;
    end
  end

  assign beat.valid = valid_r;
  assign beat.last  = last_r;
  assign beat.psum  = psum_r;

endmodule

`default_nettype wire

### rtl/twdp_acc.sv
// running sum and result register
`default_nettype none

`include "assert_macros.svh"

module twdp_acc (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire twdp_pkg::beat_t beat,
  output logic                 adv,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output twdp_pkg::acc_t       out_dot_result
);

  twdp_pkg::acc_t acc_r;
  twdp_pkg::acc_t acc_nxt;
  twdp_pkg::acc_t acc_sum;
  logic           out_valid_r;
  logic           out_valid_nxt;
  twdp_pkg::acc_t out_data_r;
  logic           out_free;
  logic           emit;

  assign out_free = ~out_valid_r | ~out_stall;
  assign adv      = beat.valid & (~beat.last | out_free);
  assign emit     = adv & beat.last;
  assign acc_sum  = acc_r + twdp_pkg::ACC_W'(beat.psum);

  always_comb begin
    acc_nxt = acc_r;
    if (adv) begin
      acc_nxt = beat.last ? '0 : acc_sum;
    end
    out_valid_nxt = emit | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= acc_sum;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dot_result = out_data_r;

  `TW_ASSERT_NEXT(a_clear_after_last, emit, acc_r == '0)
  `TW_ASSERT_NEXT(a_result_is_sum, emit, out_valid && out_dot_result == $past(acc_sum))
  `TW_ASSERT_ALWAYS(a_no_overwrite, !(emit && out_valid_r && out_stall))

endmodule

`default_nettype wire

### rtl/ternary_weight_dot_product.sv
// top level of the ternary weight dot product accumulator
// Takes one beat per clock: up to eight signed 8-bit activations with 2-bit
// weight codes (1 adds, 2 subtracts, 0 and 3 skip), of which the leading
// in_valid_lanes count, a count above eight meaning all eight. Eight lanes
// form their terms side by side and an adder tree merges them into a stage
// register; from there the partial sum is added into a 32-bit wrapping
// accumulator. On a beat marked last the finished sum moves from the stage
// register into the result register, held back only while the result
// register is still full, and the accumulator clears.
// Throughput is one beat per cycle; the input stalls only when a last beat
// waits in the stage register while the result register is still full.
`default_nettype none

module ternary_weight_dot_product (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_0,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_1,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_2,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_3,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_4,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_5,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_6,
  input  wire logic signed [twdp_pkg::ACT_W-1:0]  in_act_7,
  input  wire logic [twdp_pkg::LANES*twdp_pkg::CODE_W-1:0] in_weight_codes,
  input  wire logic [twdp_pkg::CNT_W-1:0]         in_valid_lanes,
  input  wire logic                               in_last_of_dot,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [twdp_pkg::ACC_W-1:0]       out_dot_result
);

  logic signed [twdp_pkg::ACT_W-1:0] acts [twdp_pkg::LANES];
  twdp_pkg::term_t                   terms [twdp_pkg::LANES];
  twdp_pkg::beat_t                   beat;
  logic                              adv;

  assign acts[0] = in_act_0;
  assign acts[1] = in_act_1;
  assign acts[2] = in_act_2;
  assign acts[3] = in_act_3;
  assign acts[4] = in_act_4;
  assign acts[5] = in_act_5;
  assign acts[6] = in_act_6;
  assign acts[7] = in_act_7;

  for (genvar i = 0; i < twdp_pkg::LANES; i++) begin : g_lane
    twdp_lane u_lane (
      .act    (acts[i]),
      .code   (in_weight_codes[twdp_pkg::CODE_W*i +: twdp_pkg::CODE_W]),
      .enable (in_valid_lanes > twdp_pkg::CNT_W'(i)),
      .term   (terms[i])
    );
  end

  twdp_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .terms    (terms),
    .in_valid (in_valid),
    .in_last  (in_last_of_dot),
    .in_stall (in_stall),
    .adv      (adv),
    .beat     (beat)
  );

  twdp_acc u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .beat           (beat),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dot_result (out_dot_result)
  );

endmodule

`default_nettype wire

### verif/tb_ternary_weight_dot_product.sv
// self-checking testbench for the ternary weight dot product accumulator
`timescale 1ns / 1ps

module tb_ternary_weight_dot_product;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [twdp_pkg::ACT_W-1:0] in_act_0, in_act_1, in_act_2, in_act_3;
  logic signed [twdp_pkg::ACT_W-1:0] in_act_4, in_act_5, in_act_6, in_act_7;
  logic [twdp_pkg::LANES*twdp_pkg::CODE_W-1:0] in_weight_codes;
  logic [twdp_pkg::CNT_W-1:0] in_valid_lanes;
  logic in_last_of_dot;
  logic out_valid;
  logic out_stall;
  logic signed [twdp_pkg::ACC_W-1:0] out_dot_result;

  logic signed [31:0] expected_sums[$];
  logic signed [31:0] model_acc;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned error_count;
  int unsigned beats_accepted;
  int unsigned sums_checked;
  int unsigned cycle_count;

  ternary_weight_dot_product DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_act_0        (in_act_0),
    .in_act_1        (in_act_1),
    .in_act_2        (in_act_2),
    .in_act_3        (in_act_3),
    .in_act_4        (in_act_4),
    .in_act_5        (in_act_5),
    .in_act_6        (in_act_6),
    .in_act_7        (in_act_7),
    .in_weight_codes (in_weight_codes),
    .in_valid_lanes  (in_valid_lanes),
    .in_last_of_dot  (in_last_of_dot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dot_result  (out_dot_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ternary_weight_dot_product: done, errors");
      $finish;
    end
  end

  // contribution of one beat to the running sum
  function automatic logic signed [31:0] ternary_partial(
    logic [63:0] acts,
    logic [15:0] codes,
    logic [3:0]  lanes
  );
    int n;
    logic signed [31:0] s;
    logic [1:0] c;
    logic signed [7:0] a;
    n = (lanes > twdp_pkg::LANES) ? twdp_pkg::LANES : lanes;
    s = 0;
    for (int i = 0; i < n; i++) begin
      c = codes[2*i +: 2];
      a = acts[8*i +: 8];
      if (c == twdp_pkg::CODE_PLUS) s = s + a;
      else if (c == twdp_pkg::CODE_MINUS) s = s - a;
    end
    return s;
  endfunction

  function automatic logic [63:0] rand_acts();
    logic [63:0] v;
    v = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(7))
        0: v[8*i +: 8] = 8'h80;
        1: v[8*i +: 8] = 8'h7F;
        2: v[8*i +: 8] = 8'h00;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // track accepted input beats and predict each finished sum
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      beats_accepted++;
      model_acc = model_acc + ternary_partial(
        {in_act_7, in_act_6, in_act_5, in_act_4, in_act_3, in_act_2, in_act_1, in_act_0},
        in_weight_codes, in_valid_lanes);
      if (in_last_of_dot) begin
        expected_sums.push_back(model_acc);
        model_acc = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        flag_error($sformatf("result %0d with no sum pending", out_dot_result));
      end else begin
        if (out_dot_result !== expected_sums[0])
          flag_error($sformatf("dot_result mismatch: expected %0d actual %0d",
                               expected_sums[0], out_dot_result));
        void'(expected_sums.pop_front());
        sums_checked++;
      end
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  // returns at the edge where the beat is taken; valid stays high
  task automatic send_beat(logic [63:0] acts, logic [15:0] codes, logic [3:0] lanes,
                           logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_act_0        <= acts[7:0];
    in_act_1        <= acts[15:8];
    in_act_2        <= acts[23:16];
    in_act_3        <= acts[31:24];
    in_act_4        <= acts[39:32];
    in_act_5        <= acts[47:40];
    in_act_6        <= acts[55:48];
    in_act_7        <= acts[63:56];
    in_weight_codes <= codes;
    in_valid_lanes  <= lanes;
    in_last_of_dot  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic test_extreme_activations();
    send_beat({8{8'h7F}}, 16'h5555, 4'd8, 1'b1);
    send_beat({8{8'h80}}, 16'h5555, 4'd8, 1'b1);
    send_beat({8{8'h80}}, 16'hAAAA, 4'd8, 1'b1);
    send_beat({8{8'h7F}}, 16'hAAAA, 4'd8, 1'b0);
    send_beat({8{8'h80}}, 16'hAAAA, 4'd8, 1'b1);
  endtask

  task automatic test_weight_code_decode();
    send_beat(rand_acts(), 16'hFFFF, 4'd8, 1'b1);
    send_beat(rand_acts(), 16'h0000, 4'd8, 1'b1);
    send_beat(rand_acts(), 16'hE4E4, 4'd8, 1'b1);
    send_beat(rand_acts(), 16'h1B1B, 4'd8, 1'b0);
    send_beat(rand_acts(), 16'h9C63, 4'd8, 1'b1);
  endtask

  task automatic test_lane_count_limits();
    send_beat({8{8'h7F}}, 16'h5555, 4'd1, 1'b0);
    send_beat({8{8'h80}}, 16'h5555, 4'd4, 1'b0);
    send_beat(rand_acts(), 16'hAAAA, 4'd7, 1'b0);
    send_beat({8{8'h7F}}, 16'h5555, 4'd0, 1'b1);
    send_beat({8{8'h7F}}, 16'h5555, 4'd0, 1'b1);
    send_beat(rand_acts(), 16'h5555, 4'd9, 1'b1);
    send_beat(rand_acts(), 16'hAAAA, 4'd15, 1'b1);
    send_beat(rand_acts(), 16'($urandom), 4'd3, 1'b1);
    send_beat(rand_acts(), 16'($urandom), 4'd6, 1'b1);
  endtask

  task automatic test_random_dots(int unsigned n_beats);
    int unsigned sent;
    int unsigned dot_len;
    int unsigned pick;
    logic [3:0] lanes;
    logic [15:0] codes;
    sent = 0;
    while (sent < n_beats) begin
      dot_len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
      for (int unsigned k = 0; k < dot_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 80) lanes = 4'd8;
        else if (pick < 92) lanes = 4'($urandom_range(1, 7));
        else lanes = 4'($urandom_range(0, 15));
        pick = $urandom_range(9);
        if (pick == 0) codes = 16'h5555;
        else if (pick == 1) codes = 16'hAAAA;
        else codes = 16'($urandom);
        send_beat(rand_acts(), codes, lanes, k == dot_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_act_0        <= '0;
    in_act_1        <= '0;
    in_act_2        <= '0;
    in_act_3        <= '0;
    in_act_4        <= '0;
    in_act_5        <= '0;
    in_act_6        <= '0;
    in_act_7        <= '0;
    in_weight_codes <= '0;
    in_valid_lanes  <= '0;
    in_last_of_dot  <= 1'b0;
    model_acc       = 0;
    error_count     = 0;
    beats_accepted  = 0;
    sums_checked    = 0;
    cycle_count     = 0;
    tx_idle_pct     = 27;
    rx_idle_pct     = 84;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_extreme_activations();
    test_weight_code_decode();
    test_lane_count_limits();
    test_random_dots(470);

    tx_idle_pct = 84;
    rx_idle_pct = 27;
    test_random_dots(470);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_dots(470);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats and %0d finished sums: extremes, all weight codes,",
             beats_accepted, sums_checked);
    $display("lane counts 0 to 15, under three sender and receiver backpressure mixes");
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("tb_ternary_weight_dot_product: done, clean");
    end else begin
      $display("%0d errors, %0d sums still pending", error_count, expected_sums.size());
      $display("tb_ternary_weight_dot_product: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/twdp_pkg.sv
rtl/twdp_lane.sv
rtl/twdp_sum.sv
rtl/twdp_acc.sv
rtl/ternary_weight_dot_product.sv
verif/tb_ternary_weight_dot_product.sv
